[design/bsim_pkg.sv]
// Package for the bank switch / IRQ mapper: request and result structs,
// bus address decode constants, sequencer states and remainder unit types.
// No dependencies.
package bsim_pkg;

  localparam int PrgCountW = 9;
  localparam int ChrCountW = 11;
  localparam int ModW      = ChrCountW;
  localparam int DivW      = 8;
  localparam int DivCntW   = $clog2(DivW);
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = ChrCountW;

  localparam logic [CfgIdxW-1:0] CFG_PRG_COUNT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_CHR_COUNT = 1'b1;

  localparam logic [PrgCountW-1:0] PrgCountReset = 9'd32;
  localparam logic [ChrCountW-1:0] ChrCountReset = 11'd256;
  localparam logic [PrgCountW-1:0] PrgLowReset   = 9'd0;
  localparam logic [PrgCountW-1:0] PrgMidReset   = 9'd1;
  localparam logic [PrgCountW-1:0] PrgHighReset  = PrgCountReset - 9'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic [15:0] ADDR_PRG_LOW  = 16'h8000;
  localparam logic [15:0] ADDR_MIRROR   = 16'h9000;
  localparam logic [15:0] ADDR_SWAP     = 16'h9002;
  localparam logic [15:0] ADDR_PRG_MID  = 16'ha000;
  localparam logic [15:0] ADDR_CHR_B    = 16'hb000;
  localparam logic [15:0] ADDR_CHR_C    = 16'hc000;
  localparam logic [15:0] ADDR_CHR_D    = 16'hd000;
  localparam logic [15:0] ADDR_CHR_E    = 16'he000;
  localparam logic [15:0] ADDR_IRQ      = 16'hf000;
  localparam logic [15:0] ADDR_BASE_MSK = 16'hfffc;

  localparam logic [1:0] IRQ_OFF_LATCH_HI = 2'd1;
  localparam logic [1:0] IRQ_OFF_CTRL     = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [15:0] addr;
    logic [7:0]  data;
  } bsim_req_t;

  typedef struct packed {
    logic [PrgCountW-1:0] prg_bank_low;
    logic [PrgCountW-1:0] prg_bank_mid;
    logic [PrgCountW-1:0] prg_bank_high;
    logic [1:0]           mirror_mode;
    logic                 chr_update;
    logic [2:0]           chr_slot;
    logic [7:0]           chr_page;
    logic                 irq_request;
  } bsim_res_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [ModW-1:0] modulus;
  } bsim_div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] rem;
  } bsim_div_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_FIN
  } bsim_state_e;

endpackage

[design/bsim_mod.sv]
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on bsim_pkg. A zero modulus returns the dividend unchanged.
module bsim_mod import bsim_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bsim_div_req_t req_i,
  output bsim_div_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    div_q, div_d;
  logic [DivW-1:0]    rem_q, rem_d;
  logic [ModW-1:0]    mod_q, mod_d;
  logic [DivW:0]      trial;
  logic [ModW-1:0]    trial_ext;
  logic [ModW-1:0]    diff;

  assign trial     = {rem_q, div_q[DivW-1]};
  assign trial_ext = ModW'(trial);
  assign diff      = trial_ext - mod_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    mod_d  = mod_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = req_i.dividend;
      rem_d  = '0;
      mod_d  = req_i.modulus;
    end else if (busy_q) begin
      div_d = {div_q[DivW-2:0], 1'b0};
      rem_d = (trial_ext >= mod_q) ? diff[DivW-1:0] : trial[DivW-1:0];
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    mod_q <= mod_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

[design/bank_switch_irq_mapper_top.sv]
// Bank switch / IRQ mapper top level: request decode, sequencer, bank and IRQ state.
// Depends on bsim_pkg and bsim_mod.
//
// One request is taken at a time. Program and character bank writes go through
// the load, remainder, done and write-back steps; the bit-serial remainder unit
// takes one bit of the 8-bit value per cycle against the page count. All other
// requests go from the load step straight to write-back. The result sits in an
// output register, so a new request is taken while the previous result is still
// held. A request that reaches its last step while that result is still stalled
// waits there until the result is taken. Page count registers are written through
// the config port; the user must write them only while the block is idle, which
// the block itself does not enforce. A zero page count leaves bank values unreduced.
module bank_switch_irq_mapper_top import bsim_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bsim_req_t           in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bsim_res_t           out_res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  bsim_state_e state_q, state_d;
  bsim_req_t   req_q;

  logic [PrgCountW-1:0] prg_cnt_q;
  logic [ChrCountW-1:0] chr_cnt_q;

  logic                 swap_q, swap_d;
  logic [PrgCountW-1:0] prg_q [3];
  logic [PrgCountW-1:0] prg_d [3];
  logic [1:0]           mir_q, mir_d;
  logic [7:0]           chr_pair_q [8];
  logic [7:0]           chr_pair_d [8];
  logic [7:0]           latch_q, latch_d;
  logic [7:0]           irq_cnt_q, irq_cnt_d;
  logic [7:0]           irq_ctl_q, irq_ctl_d;

  logic      out_valid_q, out_valid_d;
  bsim_res_t out_res_q, out_res_d;

  bsim_div_req_t div_req;
  bsim_div_rsp_t div_rsp;
  logic          div_start;

  logic        is_tick, w_prg_low, w_mirror, w_swap, w_prg_mid, chr_hit, irq_hit, need_mod;
  logic [15:0] base;
  logic [1:0]  off;
  logic [2:0]  slot;
  logic [7:0]  chr_val;
  logic [7:0]  cnt_inc;

  assign is_tick   = (req_q.req_type == REQ_TICK);
  assign base      = req_q.addr & ADDR_BASE_MSK;
  assign off       = req_q.addr[1:0];
  assign w_prg_low = !is_tick && (req_q.addr == ADDR_PRG_LOW);
  assign w_mirror  = !is_tick && (req_q.addr == ADDR_MIRROR);
  assign w_swap    = !is_tick && (req_q.addr == ADDR_SWAP);
  assign w_prg_mid = !is_tick && (req_q.addr == ADDR_PRG_MID);
  assign chr_hit   = !is_tick && ((base == ADDR_CHR_B) || (base == ADDR_CHR_C) ||
                                  (base == ADDR_CHR_D) || (base == ADDR_CHR_E));
  assign irq_hit   = !is_tick && (base == ADDR_IRQ);
  assign need_mod  = w_prg_low || w_prg_mid || chr_hit;

  // region B..E maps to 0..3: address bits 13:12 plus one
  assign slot    = {req_q.addr[13:12] + 2'd1, off[0]};
  assign chr_val = off[1] ? {req_q.data[3:0], chr_pair_q[slot][3:0]}
                          : {chr_pair_q[slot][7:4], req_q.data[3:0]};
  assign cnt_inc = irq_cnt_q + 8'd1;

  assign div_req.start    = div_start;
  assign div_req.dividend = chr_hit ? chr_val : req_q.data;
  assign div_req.modulus  = chr_hit ? chr_cnt_q : ModW'(prg_cnt_q);

  bsim_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    div_start   = 1'b0;
    swap_d      = swap_q;
    prg_d       = prg_q;
    mir_d       = mir_q;
    chr_pair_d  = chr_pair_q;
    latch_d     = latch_q;
    irq_cnt_d   = irq_cnt_q;
    irq_ctl_d   = irq_ctl_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_res_d   = out_res_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        div_start = need_mod;
        state_d = need_mod ? ST_CALC : ST_FIN;
      end
      ST_CALC: begin
        if (div_rsp.done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_res_d.chr_update  = 1'b0;
          out_res_d.chr_slot    = '0;
          out_res_d.chr_page    = '0;
          out_res_d.irq_request = 1'b0;
          if (is_tick) begin
            if (irq_ctl_q[1]) begin
              irq_cnt_d = cnt_inc;
              if (cnt_inc == 8'd0) begin
                out_res_d.irq_request = 1'b1;
                irq_cnt_d = latch_q;
              end
            end
          end else if (w_prg_low) begin
            if (swap_q) prg_d[2] = PrgCountW'(div_rsp.rem);
            else        prg_d[0] = PrgCountW'(div_rsp.rem);
          end else if (w_mirror) begin
            mir_d = req_q.data[1:0];
          end else if (w_swap) begin
            swap_d = req_q.data[1];
          end else if (w_prg_mid) begin
            prg_d[1] = PrgCountW'(div_rsp.rem);
          end else if (chr_hit) begin
            chr_pair_d[slot]     = chr_val;
            out_res_d.chr_update = 1'b1;
            out_res_d.chr_slot   = slot;
            out_res_d.chr_page   = div_rsp.rem;
          end else if (irq_hit) begin
            if (off <= IRQ_OFF_LATCH_HI) begin
              latch_d = req_q.data;
            end else if (off == IRQ_OFF_CTRL) begin
              if (req_q.data[1])      irq_ctl_d = 8'd1;
              else if (!req_q.data[0]) irq_ctl_d = 8'd0;
              irq_cnt_d = latch_q;
            end else begin
              irq_ctl_d = {irq_ctl_q[6:0], 1'b0} | {7'd0, irq_ctl_q[0]};
            end
          end
          out_res_d.prg_bank_low  = prg_d[0];
          out_res_d.prg_bank_mid  = prg_d[1];
          out_res_d.prg_bank_high = prg_d[2];
          out_res_d.mirror_mode   = mir_d;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      prg_cnt_q   <= PrgCountReset;
      chr_cnt_q   <= ChrCountReset;
      swap_q      <= 1'b0;
      prg_q[0]    <= PrgLowReset;
      prg_q[1]    <= PrgMidReset;
      prg_q[2]    <= PrgHighReset;
      mir_q       <= '0;
      for (int i = 0; i < 8; i++) chr_pair_q[i] <= '0;
      latch_q     <= '0;
      irq_cnt_q   <= '0;
      irq_ctl_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_index_i == CFG_PRG_COUNT) prg_cnt_q <= cfg_data_i[PrgCountW-1:0];
      if (cfg_valid_i && cfg_index_i == CFG_CHR_COUNT) chr_cnt_q <= cfg_data_i;
      swap_q      <= swap_d;
      prg_q       <= prg_d;
      mir_q       <= mir_d;
      chr_pair_q  <= chr_pair_d;
      latch_q     <= latch_d;
      irq_cnt_q   <= irq_cnt_d;
      irq_ctl_q   <= irq_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) req_q <= in_req_i;
    out_res_q <= out_res_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign cfg_ready_o = 1'b1;

endmodule

[design/bsim_chk.sv]
// Port-level checker for the bank switch / IRQ mapper, bound to the top level.
// Depends on bsim_pkg.
module bsim_chk import bsim_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input bsim_res_t out_res_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled result dropped or changed");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("new request taken while one is in work");

  a_irq_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.irq_request |-> !out_res_o.chr_update)
    else $error("irq and chr update in one result");

  a_chr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.chr_update |->
      out_res_o.chr_slot == 3'd0 && out_res_o.chr_page == 8'd0)
    else $error("chr fields set without update");

endmodule

bind bank_switch_irq_mapper_top bsim_chk u_bsim_chk (.*);
